@@ hdl/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked check, off while in reset
`define TDPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// clocked implication in the same cycle
`define TDPS_IMPLIES(label, pre, post, msg) \
  `TDPS_ASSERT(label, (pre) |-> (post), msg)
`endif

@@ hdl/tdps_pkg.sv @@
// Package of the tick driven process scheduler: sizes, codes, word types
// and small saturating helpers. No dependencies.
`default_nettype none
package tdps_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int N_W       = $clog2(MAX_PROCS + 1);

  typedef enum logic [1:0] {
    PS_NOT_STARTED = 2'd0,
    PS_RUNNING     = 2'd1,
    PS_WAITING     = 2'd2,
    PS_FINISHED    = 2'd3
  } proc_state_e;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_SRTF = 3'd2;
  localparam logic [2:0] POL_RR   = 3'd3;
  localparam logic [2:0] POL_PRR  = 3'd4;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_PCOUNT = 2'd1;
  localparam logic [1:0] REG_SLICE  = 2'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] PRI_CAP  = 2'd2;
  localparam logic [19:0] CNT_MAX  = 20'hFFFFF;

  typedef struct packed {
    logic        kind;
    logic [3:0]  slot;
    logic [15:0] arrival_time;
    logic [15:0] compute_time;
    logic [1:0]  priority_req;
  } in_word_t;

  typedef struct packed {
    logic [19:0] tick_time;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic        all_done;
    logic [23:0] sum_burst;
    logic [23:0] sum_waiting;
    logic [23:0] sum_turnaround;
  } out_word_t;

  typedef struct packed {
    proc_state_e state;
    logic [15:0] burst;
    logic [19:0] waiting;
    logic [19:0] turnaround;
  } slot_rec_t;

  function automatic logic [23:0] sat_add(input logic [23:0] acc, input logic [19:0] v);
    logic [24:0] s;
    s = {1'b0, acc} + {5'd0, v};
    return s[24] ? 24'hFFFFFF : s[23:0];
  endfunction

  function automatic logic [19:0] sat_inc(input logic [19:0] v);
    return (v == CNT_MAX) ? v : v + 20'd1;
  endfunction

endpackage
`default_nettype wire

@@ hdl/tdps_slot_upd.sv @@
// Per-slot tick update: apply the selection, count one tick, finish check.
// Depends on tdps_pkg.
`default_nettype none
module tdps_slot_upd (
  input  tdps_pkg::slot_rec_t rec_i,
  input  logic [15:0]         compute_i,
  input  logic                sel_en_i,
  input  logic                is_sel_i,
  output tdps_pkg::slot_rec_t rec_o,
  output logic                running_o
);
  import tdps_pkg::*;

  proc_state_e st;
  logic        present;

  always_comb begin
    st = rec_i.state;
    if (sel_en_i && (st == PS_RUNNING || st == PS_WAITING)) begin
      st = is_sel_i ? PS_RUNNING : PS_WAITING;
    end
    present   = (st == PS_RUNNING) || (st == PS_WAITING);
    running_o = (st == PS_RUNNING);
    rec_o.burst      = (st == PS_RUNNING) ? rec_i.burst + 16'd1 : rec_i.burst;
    rec_o.waiting    = (st == PS_WAITING) ? sat_inc(rec_i.waiting) : rec_i.waiting;
    rec_o.turnaround = present ? sat_inc(rec_i.turnaround) : rec_i.turnaround;
    // burst equal to compute finishes the slot, present or not
    rec_o.state      = (rec_o.burst == compute_i) ? PS_FINISHED : st;
  end

endmodule
`default_nettype wire

@@ hdl/tick_driven_process_scheduler.sv @@
// Tick driven process scheduler, top level.
// Input channel in_valid_i / in_stall_o carries one in_word_t: a load writes
// one process slot and restarts time, slice and rotation; a tick runs one
// scheduling step. Every item gives exactly one out_word_t on out_valid_o /
// out_stall_i, held in an output register.
// Settings come through the APB port: policy at 0x0, process_count at 0x4,
// time_slice at 0x8. pready is always high; reads return the register.
// One shared slot datapath walks the n slots in use, one slot per cycle:
//   load:  one sweep for status.
//   tick:  status sweep, arrival and selection sweep, and an update sweep;
//          round robin adds a slice check, and when the slice runs out a
//          walk to the next slot, which first wraps a pointer left beyond a
//          shrunk count. A tick on a fully finished table stops after the
//          first sweep.
// The input stalls while an item is in work; the next item is taken while a
// finished word still waits in the output register, and the last state of an
// item holds until that register is free.
// Reset clears state, counters and time and sets the settings to their defaults; slot stores are
// undefined until loaded.
`default_nettype none
module tick_driven_process_scheduler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tdps_pkg::in_word_t in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tdps_pkg::out_word_t out_word_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tdps_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    PH_IDLE, PH_PRE, PH_SCAN, PH_ROT, PH_RSTEP, PH_APPLY, PH_OUT
  } phase_e;

  // settings
  logic [2:0] policy_q;
  logic [4:0] pcount_q;
  logic [7:0] tslice_q;

  // slot table
  logic [15:0] arr_q [MAX_PROCS];
  logic [15:0] cmp_q [MAX_PROCS];
  logic [1:0]  pri_q [MAX_PROCS];
  slot_rec_t   rec_q [MAX_PROCS];

  phase_e          phase_q;
  logic [IDX_W-1:0] idx_q, rp_q, best_q, sel_idx_q, run_slot_q;
  logic [N_W-1:0]   cand_q, k_q;
  logic [7:0]       slice_q;
  logic [19:0]      time_q;
  logic             is_tick_q, done_q, found_q, any_run_q, present_q;
  logic             sel_en_q, run_found_q, adv_q;
  logic [1:0]       top_q;
  logic [17:0]      best_key_q;
  logic [23:0]      sb_q, sw_q, sa_q;
  logic             out_valid_q;
  out_word_t        out_q;

  logic [N_W-1:0]   n_w;
  logic [IDX_W-1:0] rd_idx, wr_idx;
  logic [15:0]      rd_arr, rd_cmp;
  logic [1:0]       rd_pri;
  slot_rec_t        rd_rec, upd_rec;
  logic             upd_run, first, last, accept, cfg_wr;
  logic [23:0]      sb_b, sw_b, sa_b;
  logic             done_b;
  proc_state_e      scan_st;
  logic             scan_pres;
  logic [17:0]      key;
  logic             found_n, any_n, pres_n;
  logic [IDX_W-1:0] best_n;
  logic [17:0]      best_key_n;
  logic [1:0]       top_n;
  logic             hit;

  always_comb begin
    if (pcount_q == 5'd0) begin
      n_w = N_W'(1);
    end else if (32'(pcount_q) > MAX_PROCS) begin
      n_w = N_W'(MAX_PROCS);
    end else begin
      n_w = N_W'(pcount_q);
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (phase_q != PH_IDLE);
  assign wr_idx = IDX_W'(in_word_i.slot);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    case (phase_q)
      PH_ROT:   rd_idx = rp_q;
      PH_RSTEP: rd_idx = cand_q[IDX_W-1:0];
      default:  rd_idx = idx_q;
    endcase
  end

  assign rd_arr = arr_q[rd_idx];
  assign rd_cmp = cmp_q[rd_idx];
  assign rd_pri = pri_q[rd_idx];
  assign rd_rec = rec_q[rd_idx];

  assign first = (idx_q == '0);
  assign last  = (N_W'(idx_q) == n_w - N_W'(1));

  // sweep accumulators restart at slot zero
  assign sb_b   = first ? 24'd0 : sb_q;
  assign sw_b   = first ? 24'd0 : sw_q;
  assign sa_b   = first ? 24'd0 : sa_q;
  assign done_b = first ? 1'b1 : done_q;

  // arrival and selection scan
  always_comb begin
    scan_st   = (time_q == {4'd0, rd_arr}) ? PS_WAITING : rd_rec.state;
    scan_pres = (scan_st == PS_RUNNING) || (scan_st == PS_WAITING);
    case (policy_q)
      POL_SJF:  key = {2'b00, rd_cmp};
      POL_SRTF: key = {2'b00, rd_cmp} - {2'b00, rd_rec.burst};
      default:  key = {2'b00, rd_arr};
    endcase
    found_n    = first ? 1'b0 : found_q;
    best_n     = first ? '0 : best_q;
    best_key_n = best_key_q;
    if (scan_pres && (!found_n || ($signed(key) < $signed(best_key_q)))) begin
      found_n    = 1'b1;
      best_n     = idx_q;
      best_key_n = key;
    end
    any_n  = (first ? 1'b0 : any_run_q) || (scan_st == PS_RUNNING);
    pres_n = (first ? 1'b0 : present_q) || scan_pres;
    top_n  = first ? 2'd0 : top_q;
    if (scan_pres && rd_pri > top_n) begin
      top_n = rd_pri;
    end
  end

  assign hit = ((rd_rec.state == PS_RUNNING) || (rd_rec.state == PS_WAITING)) &&
               ((policy_q != POL_PRR) || (rd_pri == top_q));

  tdps_slot_upd u_upd (
    .rec_i     (rd_rec),
    .compute_i (rd_cmp),
    .sel_en_i  (sel_en_q),
    .is_sel_i  (idx_q == sel_idx_q),
    .rec_o     (upd_rec),
    .running_o (upd_run)
  );

  // slot stores, written by loads only
  always_ff @(posedge clk_i) begin
    if (accept && in_word_i.kind == KIND_LOAD && 32'(in_word_i.slot) < MAX_PROCS) begin
      arr_q[wr_idx] <= in_word_i.arrival_time;
      cmp_q[wr_idx] <= in_word_i.compute_time;
      pri_q[wr_idx] <= (in_word_i.priority_req > PRI_CAP) ? PRI_CAP
                                                           : in_word_i.priority_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= POL_FCFS;
      pcount_q    <= 5'd1;
      tslice_q    <= 8'd4;
      phase_q     <= PH_IDLE;
      for (int i = 0; i < MAX_PROCS; i++) begin
        rec_q[i] <= '{state: PS_NOT_STARTED, burst: '0, waiting: '0, turnaround: '0};
      end
      idx_q       <= '0;
      rp_q        <= '0;
      best_q      <= '0;
      sel_idx_q   <= '0;
      run_slot_q  <= '0;
      cand_q      <= '0;
      k_q         <= '0;
      slice_q     <= '0;
      time_q      <= '0;
      is_tick_q   <= 1'b0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
      any_run_q   <= 1'b0;
      present_q   <= 1'b0;
      sel_en_q    <= 1'b0;
      run_found_q <= 1'b0;
      adv_q       <= 1'b0;
      top_q       <= '0;
      best_key_q  <= '0;
      sb_q        <= '0;
      sw_q        <= '0;
      sa_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_POLICY: policy_q <= pwdata[2:0];
          REG_PCOUNT: pcount_q <= pwdata[4:0];
          REG_SLICE:  tslice_q <= pwdata[7:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && phase_q != PH_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (phase_q)
        PH_IDLE: begin
          if (accept) begin
            is_tick_q <= (in_word_i.kind == KIND_TICK);
            idx_q     <= '0;
            phase_q   <= PH_PRE;
            if (in_word_i.kind == KIND_LOAD && 32'(in_word_i.slot) < MAX_PROCS) begin
              rec_q[wr_idx] <= '{state: PS_NOT_STARTED, burst: '0, waiting: '0,
                                 turnaround: '0};
              time_q  <= '0;
              slice_q <= '0;
              rp_q    <= '0;
            end
          end
        end
        PH_PRE: begin
          sb_q   <= sat_add(sb_b, {4'd0, rd_rec.burst});
          sw_q   <= sat_add(sw_b, rd_rec.waiting);
          sa_q   <= sat_add(sa_b, rd_rec.turnaround);
          done_q <= done_b && (rd_rec.state == PS_FINISHED);
          if (last) begin
            idx_q <= '0;
            run_found_q <= 1'b0;
            if (!is_tick_q || (done_b && (rd_rec.state == PS_FINISHED))) begin
              adv_q   <= 1'b0;
              phase_q <= PH_OUT;
            end else begin
              adv_q   <= 1'b1;
              phase_q <= PH_SCAN;
            end
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        PH_SCAN: begin
          rec_q[idx_q].state <= scan_st;
          found_q    <= found_n;
          best_q     <= best_n;
          best_key_q <= best_key_n;
          any_run_q  <= any_n;
          present_q  <= pres_n;
          top_q      <= top_n;
          if (last) begin
            idx_q     <= '0;
            sel_idx_q <= best_n;
            if (!pres_n) begin
              sel_en_q <= 1'b0;
              phase_q  <= PH_APPLY;
            end else begin
              case (policy_q)
                POL_SRTF: begin
                  sel_en_q <= 1'b1;
                  phase_q  <= PH_APPLY;
                end
                POL_RR:   phase_q  <= PH_ROT;
                POL_PRR:  phase_q  <= PH_ROT;
                default: begin
                  sel_en_q <= !any_n;
                  phase_q  <= PH_APPLY;
                end
              endcase
            end
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        PH_ROT: begin
          if (slice_q == 8'd0 || rd_rec.state == PS_FINISHED) begin
            slice_q <= tslice_q;
            cand_q  <= N_W'(rp_q) + N_W'(1);
            k_q     <= '0;
            phase_q <= PH_RSTEP;
          end else begin
            slice_q  <= slice_q - 8'd1;
            sel_en_q <= 1'b0;
            phase_q  <= PH_APPLY;
          end
        end
        PH_RSTEP: begin
          if (cand_q >= n_w) begin
            // wrap a pointer left beyond a shrunk count
            cand_q <= cand_q - n_w;
          end else begin
            rp_q <= cand_q[IDX_W-1:0];
            if (hit || k_q == n_w - N_W'(1)) begin
              sel_en_q  <= 1'b1;
              sel_idx_q <= cand_q[IDX_W-1:0];
              phase_q   <= PH_APPLY;
            end else begin
              cand_q <= cand_q + N_W'(1);
              k_q    <= k_q + N_W'(1);
            end
          end
        end
        PH_APPLY: begin
          rec_q[idx_q] <= upd_rec;
          sb_q   <= sat_add(sb_b, {4'd0, upd_rec.burst});
          sw_q   <= sat_add(sw_b, upd_rec.waiting);
          sa_q   <= sat_add(sa_b, upd_rec.turnaround);
          done_q <= done_b && (upd_rec.state == PS_FINISHED);
          if (upd_run && !run_found_q) begin
            run_found_q <= 1'b1;
            run_slot_q  <= idx_q;
          end
          if (last) begin
            idx_q   <= '0;
            phase_q <= PH_OUT;
          end else begin
            idx_q <= idx_q + IDX_W'(1);
          end
        end
        PH_OUT: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q          <= 1'b1;
            out_q.tick_time      <= is_tick_q ? time_q : 20'd0;
            out_q.running_valid  <= run_found_q;
            out_q.running_slot   <= run_found_q ? 4'(run_slot_q) : 4'd0;
            out_q.all_done       <= done_q;
            out_q.sum_burst      <= sb_q;
            out_q.sum_waiting    <= sw_q;
            out_q.sum_turnaround <= sa_q;
            if (adv_q) begin
              time_q <= time_q + 20'd1;
            end
            phase_q <= PH_IDLE;
          end
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_POLICY: prdata = {29'd0, policy_q};
      REG_PCOUNT: prdata = {27'd0, pcount_q};
      REG_SLICE:  prdata = {24'd0, tslice_q};
      default:    prdata = 32'd0;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `TDPS_IMPLIES(a_sweep_idx, (phase_q == PH_PRE || phase_q == PH_SCAN || phase_q == PH_APPLY),
                (N_W'(idx_q) < n_w), "sweep index beyond slots in use")
  `TDPS_IMPLIES(a_sel_idx, (phase_q == PH_APPLY && sel_en_q), (N_W'(sel_idx_q) < n_w),
                "selected slot beyond slots in use")
  `TDPS_IMPLIES(a_rot_steps, (phase_q == PH_RSTEP), (k_q < n_w),
                "rotation walk ran past the slot count")

endmodule
`default_nettype wire

@@ sim/tb_tick_driven_process_scheduler.sv @@
// Self-checking testbench for tick_driven_process_scheduler.
// Drives load and tick words with random gaps and output stalls, and checks every result word
// against a cycle-free model of the scheduler. Depends on tdps_pkg and the RTL only.
`default_nettype none
module tb_tick_driven_process_scheduler;
  import tdps_pkg::*;

  localparam int CLK_HALF   = 10;
  localparam int DRAIN_CYC  = 200;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int N_RANDOM   = 1950;
  localparam int N_DIR      = 19;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tick_driven_process_scheduler u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #CLK_HALF clk_i = ~clk_i;

  // scheduler model state
  logic [15:0]  arr_tbl [MAX_PROCS];
  logic [15:0]  comp_tbl [MAX_PROCS];
  logic [1:0]   prio_tbl [MAX_PROCS];
  proc_state_e  st_tbl [MAX_PROCS];
  logic [15:0]  burst_tbl [MAX_PROCS];
  logic [19:0]  wait_tbl [MAX_PROCS];
  logic [19:0]  tat_tbl [MAX_PROCS];
  logic [19:0]  now_time;
  logic [7:0]   slice_left;
  logic [3:0]   rot_ptr;
  logic [2:0]   cfg_policy;
  logic [4:0]   cfg_count;
  logic [7:0]   cfg_slice;

  out_word_t    sched_q [$];
  int           err_cnt = 0;
  int           cycle_cnt = 0;
  bit           last_done;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t e;
  } dir_row_t;

  // after reset: count 1, fcfs; slot 0 needs two ticks, then the table is finished
  dir_row_t dir_rows [N_DIR] = '{
    '{'{KIND_LOAD, 4'd0,  16'd0,     16'd2,     2'd0}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd1,  16'd65535, 16'd65535, 2'd3}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd2,  16'd0,     16'd0,     2'd2}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd3,  16'd1,     16'd1,     2'd1}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd4,  16'd2,     16'd3,     2'd3}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd5,  16'd3,     16'd5,     2'd0}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd6,  16'd4,     16'd2,     2'd2}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd7,  16'd5,     16'd4,     2'd1}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd8,  16'd6,     16'd1,     2'd0}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd9,  16'd0,     16'd6,     2'd2}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd10, 16'd7,     16'd2,     2'd3}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd11, 16'd1,     16'd3,     2'd1}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd12, 16'd2,     16'd0,     2'd0}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd13, 16'd8,     16'd2,     2'd2}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd14, 16'd3,     16'd4,     2'd1}, 1'b1, '0},
    '{'{KIND_LOAD, 4'd15, 16'hAAAA,  16'h5555,  2'd3}, 1'b1, '0},
    '{'{KIND_TICK, 4'd15, 16'hFFFF,  16'hFFFF,  2'd3}, 1'b1,
      '{20'd0, 1'b1, 4'd0, 1'b0, 24'd1, 24'd0, 24'd1}},
    '{'{KIND_TICK, 4'd0,  16'd0,     16'd0,     2'd0}, 1'b1,
      '{20'd1, 1'b1, 4'd0, 1'b1, 24'd2, 24'd0, 24'd2}},
    '{'{KIND_TICK, 4'd5,  16'h1234,  16'h4321,  2'd1}, 1'b1,
      '{20'd2, 1'b0, 4'd0, 1'b1, 24'd2, 24'd0, 24'd2}}
  };

  function automatic int slots_in_use();
    if (cfg_count == 0) return 1;
    if (cfg_count > MAX_PROCS) return MAX_PROCS;
    return cfg_count;
  endfunction

  function automatic bit is_present(int i);
    return st_tbl[i] == PS_RUNNING || st_tbl[i] == PS_WAITING;
  endfunction

  function automatic void make_running(int n, int idx);
    for (int i = 0; i < n; i++)
      if (is_present(i)) st_tbl[i] = (i == idx) ? PS_RUNNING : PS_WAITING;
  endfunction

  // key 0 arrival, 1 compute, 2 remaining; strict less keeps the lowest slot
  function automatic int pick_shortest(int n, int key);
    int best;
    int best_val;
    int v;
    best = 0;
    best_val = 32'h7FFFFFFF;
    for (int i = 0; i < n; i++) begin
      if (key == 0) v = arr_tbl[i];
      else if (key == 1) v = comp_tbl[i];
      else v = int'(comp_tbl[i]) - int'(burst_tbl[i]);
      if (is_present(i) && v < best_val) begin
        best = i;
        best_val = v;
      end
    end
    return best;
  endfunction

  function automatic bit any_running(int n);
    for (int i = 0; i < n; i++)
      if (st_tbl[i] == PS_RUNNING) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void rotate_slice(int n, bit by_prio, logic [1:0] want);
    if (slice_left == 0 || st_tbl[rot_ptr] == PS_FINISHED) begin
      slice_left = cfg_slice;
      for (int k = 0; k < n; k++) begin
        rot_ptr = 4'((int'(rot_ptr) + 1) % n);
        if (is_present(rot_ptr) && (!by_prio || prio_tbl[rot_ptr] == want)) break;
      end
      make_running(n, rot_ptr);
    end else begin
      slice_left = slice_left - 8'd1;
    end
  endfunction

  function automatic void fill_status(int n, inout out_word_t r);
    longint sb;
    longint sw;
    longint sta;
    bit done;
    sb = 0;
    sw = 0;
    sta = 0;
    done = 1'b1;
    for (int i = 0; i < n; i++) begin
      sb += burst_tbl[i];
      sw += wait_tbl[i];
      sta += tat_tbl[i];
      if (st_tbl[i] != PS_FINISHED) done = 1'b0;
    end
    r.all_done = done;
    r.sum_burst = sb > 24'hFFFFFF ? 24'hFFFFFF : 24'(sb);
    r.sum_waiting = sw > 24'hFFFFFF ? 24'hFFFFFF : 24'(sw);
    r.sum_turnaround = sta > 24'hFFFFFF ? 24'hFFFFFF : 24'(sta);
  endfunction

  function automatic logic [19:0] sat_inc_tb(logic [19:0] v);
    return (v == 20'hFFFFF) ? v : v + 20'd1;
  endfunction

  function automatic out_word_t schedule_word(in_word_t w);
    out_word_t r;
    int n;
    int s;
    bit present;
    logic [1:0] top;
    n = slots_in_use();
    r = '0;
    if (w.kind == KIND_LOAD) begin
      s = w.slot;
      arr_tbl[s] = w.arrival_time;
      comp_tbl[s] = w.compute_time;
      prio_tbl[s] = (w.priority_req > PRI_CAP) ? PRI_CAP : w.priority_req;
      st_tbl[s] = PS_NOT_STARTED;
      burst_tbl[s] = '0;
      wait_tbl[s] = '0;
      tat_tbl[s] = '0;
      now_time = '0;
      slice_left = '0;
      rot_ptr = '0;
      fill_status(n, r);
      return r;
    end
    fill_status(n, r);
    r.tick_time = now_time;
    if (r.all_done) return r;
    for (int i = 0; i < n; i++)
      if (now_time == 20'(arr_tbl[i])) st_tbl[i] = PS_WAITING;
    present = 1'b0;
    top = '0;
    for (int i = 0; i < n; i++)
      if (is_present(i)) begin
        present = 1'b1;
        if (prio_tbl[i] > top) top = prio_tbl[i];
      end
    if (present) begin
      case (cfg_policy)
        POL_SJF:  if (!any_running(n)) make_running(n, pick_shortest(n, 1));
        POL_SRTF: make_running(n, pick_shortest(n, 2));
        POL_RR:   rotate_slice(n, 1'b0, '0);
        POL_PRR:  rotate_slice(n, 1'b1, top);
        default:  if (!any_running(n)) make_running(n, pick_shortest(n, 0));
      endcase
    end
    for (int i = 0; i < n; i++)
      if (st_tbl[i] == PS_RUNNING) begin
        r.running_valid = 1'b1;
        r.running_slot = 4'(i);
        break;
      end
    now_time = now_time + 20'd1;
    for (int i = 0; i < n; i++) begin
      if (st_tbl[i] == PS_RUNNING) begin
        burst_tbl[i] = burst_tbl[i] + 16'd1;
        tat_tbl[i] = sat_inc_tb(tat_tbl[i]);
      end else if (st_tbl[i] == PS_WAITING) begin
        wait_tbl[i] = sat_inc_tb(wait_tbl[i]);
        tat_tbl[i] = sat_inc_tb(tat_tbl[i]);
      end
    end
    for (int i = 0; i < n; i++)
      if (burst_tbl[i] == comp_tbl[i]) st_tbl[i] = PS_FINISHED;
    fill_status(n, r);
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_POLICY: cfg_policy = val[2:0];
      REG_PCOUNT: cfg_count = val[4:0];
      default:    cfg_slice = val[7:0];
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // hold valid until taken; the caller decides whether to drop it afterwards
  task automatic send_word(in_word_t w, bit typed, out_word_t e);
    out_word_t p;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_word_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    p = schedule_word(w);
    last_done = p.all_done;
    sched_q.push_back(typed ? e : p);
  endtask

  int burst_left = 0;

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80) : $urandom_range(0, 8);
    gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (sched_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    w.kind = 1'($urandom_range(0, 1));
    w.slot = 4'($urandom);
    w.arrival_time = 16'($urandom);
    w.compute_time = 16'($urandom);
    w.priority_req = 2'($urandom);
    return w;
  endfunction

  task automatic run_phase(logic [2:0] pol, logic [4:0] cnt, logic [7:0] slc, int quota);
    in_word_t w;
    int n;
    int sent;
    int ticks;
    drain();
    write_reg(REG_POLICY, {29'd0, pol});
    write_reg(REG_PCOUNT, {27'd0, cnt});
    write_reg(REG_SLICE, {24'd0, slc});
    n = slots_in_use();
    sent = 0;
    while (sent < quota) begin
      for (int s = 0; s < n; s++) begin
        w.kind = KIND_LOAD;
        w.slot = 4'(s);
        w.arrival_time = 16'($urandom_range(0, 12));
        w.compute_time = 16'($urandom_range(0, 7));
        w.priority_req = 2'($urandom);
        if ($urandom_range(0, 19) == 0) w = noise_word();
        send_word(w, 1'b0, '0);
        pace();
        sent++;
      end
      ticks = 0;
      last_done = 1'b0;
      while (!last_done && ticks < 60) begin
        w = noise_word();
        w.kind = KIND_TICK;
        if ($urandom_range(0, 29) == 0) w = noise_word();
        send_word(w, 1'b0, '0);
        pace();
        sent++;
        ticks++;
      end
    end
  endtask

  // receiver: the stall pattern switches among three random modes
  int stall_mode = 0;
  int stall_len = 0;
  always @(negedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_len = $urandom_range(20, 120);
    end
    stall_len--;
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sched_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_word_o);
        err_cnt++;
      end else begin
        e = sched_q.pop_front();
        if (out_word_o.tick_time !== e.tick_time) begin
          $error("tick_time expected %0d got %0d", e.tick_time, out_word_o.tick_time);
          err_cnt++;
        end
        if (out_word_o.running_valid !== e.running_valid) begin
          $error("running_valid expected %0d got %0d", e.running_valid,
                 out_word_o.running_valid);
          err_cnt++;
        end
        if (out_word_o.running_slot !== e.running_slot) begin
          $error("running_slot expected %0d got %0d", e.running_slot, out_word_o.running_slot);
          err_cnt++;
        end
        if (out_word_o.all_done !== e.all_done) begin
          $error("all_done expected %0d got %0d", e.all_done, out_word_o.all_done);
          err_cnt++;
        end
        if (out_word_o.sum_burst !== e.sum_burst) begin
          $error("sum_burst expected %0d got %0d", e.sum_burst, out_word_o.sum_burst);
          err_cnt++;
        end
        if (out_word_o.sum_waiting !== e.sum_waiting) begin
          $error("sum_waiting expected %0d got %0d", e.sum_waiting, out_word_o.sum_waiting);
          err_cnt++;
        end
        if (out_word_o.sum_turnaround !== e.sum_turnaround) begin
          $error("sum_turnaround expected %0d got %0d", e.sum_turnaround,
                 out_word_o.sum_turnaround);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [2:0] pol_list [8] = '{POL_FCFS, POL_SJF, POL_SRTF, POL_RR, POL_PRR,
                                 3'd5, 3'd7, POL_RR};
    logic [4:0] cnt_list [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd3, 5'd2};
    logic [7:0] slc_list [5] = '{8'd0, 8'd1, 8'd255, 8'd2, 8'd4};
    int phase;
    for (int i = 0; i < MAX_PROCS; i++) begin
      arr_tbl[i] = '0;
      comp_tbl[i] = '0;
      prio_tbl[i] = '0;
      st_tbl[i] = PS_NOT_STARTED;
      burst_tbl[i] = '0;
      wait_tbl[i] = '0;
      tat_tbl[i] = '0;
    end
    now_time = '0;
    slice_left = '0;
    rot_ptr = '0;
    cfg_policy = POL_FCFS;
    cfg_count = 5'd1;
    cfg_slice = 8'd4;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: every slot gets loaded first, so no tick reads an unwritten slot
    for (int r = 0; r < N_DIR; r++) begin
      send_word(dir_rows[r].w, dir_rows[r].typed, dir_rows[r].e);
      pace();
    end

    phase = 0;
    while (phase < 32) begin
      run_phase(pol_list[phase % 8], cnt_list[phase % 6],
                (phase % 3 == 0) ? 8'($urandom_range(0, 6)) : slc_list[phase % 5],
                N_RANDOM / 32);
      phase++;
    end

    drain();
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
